>>> rtl/bgd_pkg.sv
// Shared types, codes and sizes for the button gesture detector.
// No dependencies; every other file refers to it by scoped names.
package bgd_pkg;

  // Event queue sizing
  localparam int unsigned FIFO_DEPTH = 32;
  localparam int unsigned PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Field widths
  localparam int unsigned EV_W    = 3;
  localparam int unsigned PIN_W   = 2;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned DEB_W   = 8;
  localparam int unsigned LONG_W  = 16;

  // Command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Gesture phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_PRESSED  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_HELD     = 2'd3;

  // Event codes
  localparam logic [EV_W-1:0] EV_SHORT        = 3'd0;
  localparam logic [EV_W-1:0] EV_HOLD         = 3'd1;
  localparam logic [EV_W-1:0] EV_LONG_RELEASE = 3'd2;
  localparam logic [EV_W-1:0] EV_BOTH         = 3'd3;
  localparam logic [EV_W-1:0] EV_NONE         = 3'd4;

  // Pin patterns
  localparam logic [PIN_W-1:0] PINS_RELEASED = 2'b00;
  localparam logic [PIN_W-1:0] PINS_BOTH     = 2'b11;

  // Register map (word index) and reset values
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 8'd10;
  localparam logic [LONG_W-1:0] LONG_PRESS_RST = 16'd3000;

  // Event push request from the gesture tracker to the queue
  typedef struct packed {
    logic            valid;
    logic [EV_W-1:0] ev;
  } push_req_t;

endpackage

>>> rtl/bgd_regs.sv
// APB-style configuration registers: debounce and long-press limits.
// Depends on bgd_pkg.
module bgd_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bgd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [bgd_pkg::DEB_W-1:0]  debounce_ticks_o,
  output logic [bgd_pkg::LONG_W-1:0] long_press_ticks_o
);

  logic                       wr_en;
  logic                       reg_sel;
  logic [bgd_pkg::DEB_W-1:0]  debounce_q;
  logic [bgd_pkg::LONG_W-1:0] long_press_q;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bgd_pkg::DEBOUNCE_RST;
      long_press_q <= bgd_pkg::LONG_PRESS_RST;
    end else if (wr_en) begin
      if (reg_sel == bgd_pkg::REG_DEBOUNCE) begin
        debounce_q <= pwdata[bgd_pkg::DEB_W-1:0];
      end else begin
        long_press_q <= pwdata[bgd_pkg::LONG_W-1:0];
      end
    end
  end

  // Read back the selected register
  always_comb begin
    prdata = '0;
    case (reg_sel)
      bgd_pkg::REG_DEBOUNCE:   prdata[bgd_pkg::DEB_W-1:0]  = debounce_q;
      bgd_pkg::REG_LONG_PRESS: prdata[bgd_pkg::LONG_W-1:0] = long_press_q;
      default:                 prdata = '0;
    endcase
  end

  assign debounce_ticks_o   = debounce_q;
  assign long_press_ticks_o = long_press_q;

endmodule

>>> rtl/bgd_gesture.sv
// Press tracker: debounce, press timing and gesture classification per tick.
// Depends on bgd_pkg; emits push requests for the event queue.
module bgd_gesture (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_en_i,
  input  logic [bgd_pkg::PIN_W-1:0]   pins_i,
  input  logic [bgd_pkg::DEB_W-1:0]   debounce_ticks_i,
  input  logic [bgd_pkg::LONG_W-1:0]  long_press_ticks_i,
  output bgd_pkg::push_req_t          push_o,
  output logic [bgd_pkg::PHASE_W-1:0] phase_next_o
);

  logic [bgd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [bgd_pkg::LONG_W-1:0]  timer_q, timer_d;
  logic [bgd_pkg::DEB_W-1:0]   deb_q, deb_d;
  logic [bgd_pkg::DEB_W:0]     deb_inc;
  logic [bgd_pkg::LONG_W:0]    timer_inc;
  logic                        released;

  assign deb_inc   = {1'b0, deb_q} + 1'b1;
  assign timer_inc = {1'b0, timer_q} + 1'b1;
  assign released  = (pins_i == bgd_pkg::PINS_RELEASED);

  // Advance the phase on each tick
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    deb_d   = deb_q;
    push_o  = '{valid: 1'b0, ev: bgd_pkg::EV_SHORT};
    if (tick_en_i) begin
      case (phase_q)
        bgd_pkg::PH_IDLE: begin
          if (!released) begin
            phase_d = bgd_pkg::PH_DEBOUNCE;
            deb_d   = '0;
          end
          timer_d = '0;
        end
        bgd_pkg::PH_DEBOUNCE: begin
          if (deb_inc >= {1'b0, debounce_ticks_i}) begin
            deb_d   = '0;
            timer_d = '0;
            phase_d = released ? bgd_pkg::PH_IDLE : bgd_pkg::PH_PRESSED;
          end else begin
            deb_d = deb_inc[bgd_pkg::DEB_W-1:0];
          end
        end
        bgd_pkg::PH_PRESSED: begin
          if (timer_inc > {1'b0, long_press_ticks_i}) begin
            push_o.valid = 1'b1;
            push_o.ev    = (pins_i == bgd_pkg::PINS_BOTH) ? bgd_pkg::EV_BOTH
                                                          : bgd_pkg::EV_HOLD;
            timer_d = '0;
            phase_d = bgd_pkg::PH_HELD;
          end else if (released) begin
            push_o.valid = 1'b1;
            push_o.ev    = bgd_pkg::EV_SHORT;
            timer_d = '0;
            phase_d = bgd_pkg::PH_IDLE;
          end else begin
            timer_d = timer_inc[bgd_pkg::LONG_W-1:0];
          end
        end
        default: begin
          // held: report the release of a long press
          if (released) begin
            push_o.valid = 1'b1;
            push_o.ev    = bgd_pkg::EV_LONG_RELEASE;
            timer_d = '0;
            phase_d = bgd_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bgd_pkg::PH_IDLE;
      timer_q <= '0;
      deb_q   <= '0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      deb_q   <= deb_d;
    end
  end

  assign phase_next_o = phase_d;

endmodule

>>> rtl/bgd_fifo.sv
// Circular event queue with drop-on-full and pop-on-command.
// Depends on bgd_pkg for depth, pointer widths and event codes.
module bgd_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bgd_pkg::push_req_t        push_i,
  input  logic                      pop_en_i,
  input  logic                      load_i,
  output logic [bgd_pkg::EV_W-1:0]  pop_data_o,
  output logic [bgd_pkg::CNT_W-1:0] count_next_o,
  output logic                      dropped_o
);

  localparam logic [bgd_pkg::PTR_W-1:0] LastPtr = bgd_pkg::PTR_W'(bgd_pkg::FIFO_DEPTH - 1);
  localparam logic [bgd_pkg::CNT_W-1:0] FullCnt = bgd_pkg::CNT_W'(bgd_pkg::FIFO_DEPTH);

  logic [bgd_pkg::EV_W-1:0]  store_q [bgd_pkg::FIFO_DEPTH];
  logic [bgd_pkg::EV_W-1:0]  pop_data_q;
  logic [bgd_pkg::PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [bgd_pkg::PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [bgd_pkg::CNT_W-1:0] fill_q, fill_d;
  logic                      full;
  logic                      empty;
  logic                      do_push;
  logic                      do_pop;

  assign full    = (fill_q == FullCnt);
  assign empty   = (fill_q == '0);
  assign do_push = push_i.valid & ~full;
  assign do_pop  = pop_en_i & ~empty;

  // Move pointers and fill count
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      fill_d   = fill_q + 1'b1;
    end else if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      fill_d   = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the word at the write pointer; on a load, capture the head word on a pop, else EV_NONE
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_i.ev;
    end
    if (load_i) begin
      pop_data_q <= do_pop ? store_q[rd_ptr_q] : bgd_pkg::EV_NONE;
    end
  end

  assign pop_data_o   = pop_data_q;
  assign count_next_o = fill_d;
  assign dropped_o    = push_i.valid & full;

endmodule

>>> rtl/button_gesture_detector_fifo_top.sv
// Button gesture detector with event queue, top level.
// An accepted word is held in the input register, then registered into the result register.
// Throughput: one word per cycle while the consumer takes results, set by the single-pass update stage.
// Reset (rst_ni low, asynchronous): phase idle, timers and queue empty,
// registers at debounce 10 and long press 3000; no result pending.
// Depends on bgd_pkg, bgd_regs, bgd_gesture, bgd_fifo.
module button_gesture_detector_fifo_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [bgd_pkg::PIN_W-1:0]   pin_levels_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bgd_pkg::EV_W-1:0]    popped_event_o,
  output logic [bgd_pkg::CNT_W-1:0]   event_count_o,
  output logic                        overflow_o,
  output logic [bgd_pkg::PHASE_W-1:0] phase_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic                        s1_valid_q;
  logic                        s1_cmd_q;
  logic [bgd_pkg::PIN_W-1:0]   s1_pins_q;
  logic                        out_valid_q;
  logic [bgd_pkg::CNT_W-1:0]   cnt_q;
  logic                        ovf_q;
  logic [bgd_pkg::PHASE_W-1:0] phase_q;
  logic                        advance;
  logic                        fire;
  logic                        in_accept;
  logic [bgd_pkg::DEB_W-1:0]   debounce_ticks;
  logic [bgd_pkg::LONG_W-1:0]  long_press_ticks;
  bgd_pkg::push_req_t          push;
  logic [bgd_pkg::PHASE_W-1:0] phase_next;
  logic [bgd_pkg::EV_W-1:0]    pop_data;
  logic [bgd_pkg::CNT_W-1:0]   count_next;
  logic                        dropped;

  assign advance    = ~out_valid_q | out_ready_i;
  assign fire       = s1_valid_q & advance;
  assign in_ready_o = ~s1_valid_q | advance;
  assign in_accept  = in_valid_i & in_ready_o;

  bgd_regs u_regs (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .debounce_ticks_o   (debounce_ticks),
    .long_press_ticks_o (long_press_ticks)
  );

  bgd_gesture u_gesture (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .tick_en_i          (fire & (s1_cmd_q == bgd_pkg::CMD_TICK)),
    .pins_i             (s1_pins_q),
    .debounce_ticks_i   (debounce_ticks),
    .long_press_ticks_i (long_press_ticks),
    .push_o             (push),
    .phase_next_o       (phase_next)
  );

  // The queue registers the popped word itself, alongside the result register
  bgd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_en_i     (fire & (s1_cmd_q == bgd_pkg::CMD_POP)),
    .load_i       (fire),
    .pop_data_o   (pop_data),
    .count_next_o (count_next),
    .dropped_o    (dropped)
  );

  // Input register: hold the word until the update stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q  <= command_i;
      s1_pins_q <= pin_levels_i;
    end
  end

  // Result register: hold until the consumer takes the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cnt_q   <= count_next;
      ovf_q   <= dropped;
      phase_q <= phase_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_event_o = pop_data;
  assign event_count_o  = cnt_q;
  assign overflow_o     = ovf_q;
  assign phase_o        = phase_q;

endmodule

>>> rtl/bgd_checker.sv
// Port-level checks on the gesture detector's result channel, and the bind
// that attaches them to the top level. Depends on bgd_pkg.
module bgd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [bgd_pkg::EV_W-1:0]    popped_event_o,
  input logic [bgd_pkg::CNT_W-1:0]   event_count_o,
  input logic                        overflow_o,
  input logic [bgd_pkg::PHASE_W-1:0] phase_o
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(popped_event_o)
      && $stable(event_count_o) && $stable(overflow_o) && $stable(phase_o))
    else $error("result word changed while stalled");

  // A drop only happens with the queue full
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      event_count_o == bgd_pkg::CNT_W'(bgd_pkg::FIFO_DEPTH))
    else $error("overflow reported with queue not full");

  // A dropping tick pops nothing
  a_ovf_nopop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> popped_event_o == bgd_pkg::EV_NONE)
    else $error("overflow reported on a popping word");

  // Count never exceeds the queue depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> event_count_o <= bgd_pkg::CNT_W'(bgd_pkg::FIFO_DEPTH))
    else $error("event count above queue depth");

endmodule

bind button_gesture_detector_fifo_top bgd_checker u_bgd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .popped_event_o (popped_event_o),
  .event_count_o  (event_count_o),
  .overflow_o     (overflow_o),
  .phase_o        (phase_o)
);
